@@ rtl/mcedf_pkg.sv @@
// Shared types and constants for the EDF-VD mixed-criticality scheduler core.
`timescale 1ns / 1ps
package mcedf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UW        = FRAC_BITS + 1;      // utilization, Q1.16 (1.0 = ONE_Q)
    localparam int BW        = 24;                 // signed budget, Q7.16
    localparam int DVW       = 2 * FRAC_BITS + 2;  // divider dividend / quotient
    localparam int DVCW      = $clog2(DVW);

    localparam logic [UW-1:0] ONE_Q   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [UW-1:0] EPS_Q   = UW'((1 << FRAC_BITS) / 10000);
    localparam logic [BW-1:0] BUD_MAX = {1'b0, {(BW-1){1'b1}}};
    localparam logic [BW-1:0] BUD_MIN = {1'b1, {(BW-1){1'b0}}};

    localparam logic [2:0] CFG_QUANTUM = 3'd0;
    localparam logic [2:0] CFG_TCOUNT  = 3'd1;
    localparam logic [2:0] CFG_ULOW    = 3'd2;
    localparam logic [2:0] CFG_UHIGH   = 3'd3;
    localparam logic [2:0] CFG_LAMBDA  = 3'd4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DEMAND = 2'd1,
        OP_START  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_READY   = 2'd0,
        PH_RUNNING = 2'd1,
        PH_IDLE    = 2'd2
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_MUL, S_INIT, S_CHECK, S_RTEST,
        S_ULO_GO, S_ULO_W, S_UHI_GO, S_UHI_W, S_PROD, S_RQ_GO, S_RQ_W,
        S_BUD_GO, S_BUD_W, S_RSET, S_UTIL_GO, S_UTIL_W, S_DROP_CHK, S_DROP_SCAN,
        S_MISS, S_REL_MUL, S_REL, S_PICK, S_RCHK, S_RESTORE, S_EXEC, S_OUT
    } t_state;

endpackage

@@ rtl/mixed_criticality_edf_vd_drop_scheduler_core.sv @@
// EDF-VD mixed-criticality scheduler with low-task dropping, sequencer and shared units.
// One request at a time. At a scheduling point the sequencer makes passes over the
// tasks in use (n), most of them one task per cycle. A mode raise adds 3+n divisions
// on the shared radix-2 divider, 4+n when the budget shrinks. Synchronous active-low
// reset: all jobs ready and enabled with cleared counters and deadlines, low mode,
// zero budget; the task table is not reset.
`timescale 1ns / 1ps
module mixed_criticality_edf_vd_drop_scheduler_core #(
    parameter int MAX_TASKS  = 8,
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // task_index[2:0], task_period[18:3], low_budget[34:19], high_budget[50:35],
    // is_high_crit[51], job_demand[67:52], zero pad [71:68]
    input  logic [71:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // running_task[2:0], running_valid[3], high_mode_active[4], sched_point[5],
    // done_low_count[9:6], done_high_count[13:10], miss_low_count[17:14],
    // miss_high_count[21:18], dropped_count[25:22], current_time[57:26], zero pad [63:58]
    output logic [63:0] m_axis_tdata
);
    import mcedf_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = TIME_WIDTH;

    t_state r_state, n_state;

    // configuration
    logic [15:0]   r_quantum;
    logic [3:0]    r_tcount;
    logic [UW-1:0] r_ucrit, r_uhigh;
    logic [15:0]   r_lambda;

    // task table, loaded by requests only
    logic [15:0] r_per [MAX_TASKS];
    logic [15:0] r_lob [MAX_TASKS];
    logic [15:0] r_hib [MAX_TASKS];
    logic [15:0] r_dem [MAX_TASKS];
    logic        r_crit [MAX_TASKS];

    // per-task job state
    t_phase        r_phase [MAX_TASKS];
    logic          r_raised [MAX_TASKS];
    logic          r_en [MAX_TASKS];
    logic [15:0]   r_exec [MAX_TASKS];
    logic [TW-1:0] r_wake [MAX_TASKS];
    logic [TW-1:0] r_vdl [MAX_TASKS];
    logic [TW-1:0] r_rdl [MAX_TASKS];
    logic [UW-1:0] r_ulow [MAX_TASKS];

    // global state
    logic [IW-1:0] r_run;
    logic          r_run_v;
    logic          r_mode;
    logic [BW-1:0] r_bud;
    logic [UW-1:0] r_elu;
    logic [TW-1:0] r_time;
    logic [15:0]   r_qph;

    // sequencer scratch
    logic [CW-1:0] r_i, r_k;
    logic [UW-1:0] r_ulo, r_uhi, r_dmag;
    logic          r_best_v;
    logic [IW-1:0] r_best;
    logic [TW-1:0] r_best_vdl;
    logic [UW-1:0] r_best_u;
    logic          r_sched;
    logic [3:0]    r_dl, r_dh, r_ml, r_mh, r_dr;
    logic [63:0]   r_out;

    // shared multiplier
    logic [DVW-1:0] r_mul;
    logic [UW-1:0]  w_mul_a, w_mul_b;

    // shared divider
    logic            r_dv_busy;
    logic [DVCW-1:0] r_dv_cnt;
    logic [UW-1:0]   r_dv_rem, r_dv_dvs;
    logic [DVW-1:0]  r_dv_quo;
    logic            w_dv_go;
    logic [DVW-1:0]  w_dv_a;
    logic [UW-1:0]   w_dv_b;
    logic [UW:0]     w_dv_rs;
    logic            w_dv_ge;

    // decode
    logic          w_in_acc;
    t_op           w_op;
    logic [IW-1:0] w_idx;
    logic          w_idx_ok;
    logic [CW-1:0] w_n;
    logic [IW-1:0] w_ii;
    logic          w_end, w_init_end;
    logic          w_over [MAX_TASKS];
    logic [UW-1:0] w_pnz [MAX_TASKS];
    logic          w_run_done, w_sched, w_raise;
    logic [UW-1:0] w_dv_sat, w_omu, w_h, w_den, w_dmag;
    logic          w_rq_neg;
    logic signed [DVW:0] w_bsum;
    logic [BW-1:0] w_bnew;
    logic          w_drop_go, w_dcand, w_miss, w_rel, w_pcand, w_rcand;
    logic [TW-1:0] w_scaled, w_wake_per;
    logic [16:0]   w_qnext;
    logic [15:0]   w_q;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_op     = t_op'(s_axis_tuser);
    assign w_idx    = IW'(s_axis_tdata[2:0]);
    assign w_idx_ok = (32'(s_axis_tdata[2:0]) < MAX_TASKS);
    assign w_n      = (32'(r_tcount) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(r_tcount);
    assign w_ii     = r_i[IW-1:0];
    assign w_end      = (r_i == w_n);
    assign w_init_end = (r_i == CW'(MAX_TASKS));

    always_comb begin
        for (int j = 0; j < MAX_TASKS; j++) begin
            w_over[j] = (r_exec[j] > r_lob[j]) && !r_raised[j];
            w_pnz[j]  = (r_per[j] == 16'd0) ? UW'(1) : {1'b0, r_per[j]};
        end
    end

    // scheduling point test: quantum boundary or an event on the running job
    assign w_run_done = r_exec[r_run] >= r_dem[r_run];
    assign w_sched = (r_qph == 16'd0) ||
                     (r_run_v && (w_run_done || w_over[r_run] || (r_time > r_rdl[r_run])));
    assign w_raise = r_run_v && w_over[r_run] && r_crit[r_run];

    // budget arithmetic
    assign w_dv_sat = (r_dv_quo > DVW'(ONE_Q)) ? ONE_Q : r_dv_quo[UW-1:0];
    assign w_omu    = (r_ucrit < ONE_Q) ? (ONE_Q - r_ucrit) : '0;
    assign w_h      = (r_uhigh == '0) ? UW'(1) : r_uhigh;
    assign w_den    = ONE_Q - {1'b0, r_lambda};
    assign w_rq_neg = r_dv_quo < DVW'(r_uhi);
    assign w_dmag   = r_uhi - r_dv_quo[UW-1:0];
    assign w_bsum   = $signed({{(DVW+1-BW){r_bud[BW-1]}}, r_bud}) - $signed({1'b0, r_dv_quo});
    assign w_bnew   = (w_bsum < $signed({{(DVW+1-BW){1'b1}}, BUD_MIN})) ? BUD_MIN :
                      (w_bsum > $signed({{(DVW+1-BW){1'b0}}, BUD_MAX})) ? BUD_MAX :
                      w_bsum[BW-1:0];

    // drop while enabled low utilization exceeds the budget and epsilon, up to MAX_TASKS drops
    assign w_drop_go = (r_bud[BW-1] || ({{(BW-UW){1'b0}}, r_elu} > r_bud)) &&
                       (r_elu > EPS_Q) && (r_k < CW'(MAX_TASKS));
    assign w_dcand = !r_crit[w_ii] && r_en[w_ii] && (!r_best_v || r_ulow[w_ii] > r_best_u);
    assign w_miss  = (r_phase[w_ii] == PH_READY || r_phase[w_ii] == PH_RUNNING) &&
                     ((r_time > r_rdl[w_ii]) || w_over[w_ii]);
    assign w_rel   = (r_phase[w_ii] == PH_IDLE) && (r_time >= r_wake[w_ii]);
    assign w_pcand = (r_phase[w_ii] == PH_READY) && r_en[w_ii] &&
                     (!r_best_v || r_vdl[w_ii] < r_best_vdl);
    assign w_rcand = (r_phase[w_ii] == PH_READY) && (!r_run_v || r_vdl[w_ii] < r_best_vdl);

    assign w_scaled   = TW'(r_mul[DVW-1:FRAC_BITS]);
    assign w_wake_per = r_wake[w_ii] + TW'(r_per[w_ii]);
    assign w_q        = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign w_qnext    = {1'b0, r_qph} + 17'd1;

    // shared multiplier operands
    assign w_mul_a = (r_state == S_PROD) ? r_ulo : {1'b0, r_per[w_ii]};
    assign w_mul_b = (r_state == S_PROD) ? w_omu : {1'b0, r_lambda};

    assign w_dv_rs = {r_dv_rem, r_dv_quo[DVW-1]};
    assign w_dv_ge = w_dv_rs >= {1'b0, r_dv_dvs};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (w_op)
                        OP_START: n_state = S_INIT_MUL;
                        OP_TICK:  n_state = S_CHECK;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_INIT_MUL:  n_state = w_init_end ? S_OUT : S_INIT;
            S_INIT:      n_state = S_INIT_MUL;
            S_CHECK:     n_state = w_sched ? S_RTEST : S_EXEC;
            S_RTEST:     n_state = w_raise ? S_ULO_GO : S_MISS;
            S_ULO_GO:    n_state = S_ULO_W;
            S_ULO_W:     if (!r_dv_busy) n_state = S_UHI_GO;
            S_UHI_GO:    n_state = S_UHI_W;
            S_UHI_W:     if (!r_dv_busy) n_state = S_PROD;
            S_PROD:      n_state = S_RQ_GO;
            S_RQ_GO:     n_state = S_RQ_W;
            S_RQ_W:      if (!r_dv_busy) n_state = w_rq_neg ? S_BUD_GO : S_RSET;
            S_BUD_GO:    n_state = S_BUD_W;
            S_BUD_W:     if (!r_dv_busy) n_state = S_RSET;
            S_RSET:      n_state = S_UTIL_GO;
            S_UTIL_GO:   n_state = w_end ? S_DROP_CHK : S_UTIL_W;
            S_UTIL_W:    if (!r_dv_busy) n_state = S_UTIL_GO;
            S_DROP_CHK:  n_state = w_drop_go ? S_DROP_SCAN : S_MISS;
            S_DROP_SCAN: if (w_end) n_state = r_best_v ? S_DROP_CHK : S_MISS;
            S_MISS:      if (w_end) n_state = S_REL_MUL;
            S_REL_MUL:   n_state = w_end ? S_PICK : S_REL;
            S_REL:       n_state = S_REL_MUL;
            S_PICK:      if (w_end) n_state = S_RCHK;
            S_RCHK:      n_state = (!r_run_v && r_mode) ? S_RESTORE : S_EXEC;
            S_RESTORE:   if (w_end) n_state = S_EXEC;
            S_EXEC:      n_state = S_OUT;
            S_OUT:       if (m_axis_tready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // divider launch and operands
    always_comb begin
        w_dv_go = 1'b0;
        w_dv_a  = '0;
        w_dv_b  = UW'(1);
        case (r_state)
            S_ULO_GO: begin
                w_dv_go = 1'b1;
                w_dv_a  = DVW'({r_lob[r_run], {FRAC_BITS{1'b0}}});
                w_dv_b  = w_pnz[r_run];
            end
            S_UHI_GO: begin
                w_dv_go = 1'b1;
                w_dv_a  = DVW'({r_hib[r_run], {FRAC_BITS{1'b0}}});
                w_dv_b  = w_pnz[r_run];
            end
            S_RQ_GO: begin
                w_dv_go = 1'b1;
                w_dv_a  = r_mul;
                w_dv_b  = w_h;
            end
            S_BUD_GO: begin
                w_dv_go = 1'b1;
                w_dv_a  = DVW'({r_dmag, {FRAC_BITS{1'b0}}});
                w_dv_b  = w_den;
            end
            S_UTIL_GO: begin
                w_dv_go = !w_end;
                w_dv_a  = DVW'({r_lob[w_ii], {FRAC_BITS{1'b0}}});
                w_dv_b  = w_pnz[w_ii];
            end
            default: begin
                w_dv_go = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= 16'd1;
            r_tcount  <= 4'd1;
            r_ucrit   <= '0;
            r_uhigh   <= ONE_Q;
            r_lambda  <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_QUANTUM: r_quantum <= i_cfg_data[15:0];
                CFG_TCOUNT:  r_tcount  <= i_cfg_data[3:0];
                CFG_ULOW:    r_ucrit   <= i_cfg_data;
                CFG_UHIGH:   r_uhigh   <= i_cfg_data;
                CFG_LAMBDA:  r_lambda  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // task table
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_idx_ok) begin
            if (w_op == OP_LOAD) begin
                r_per[w_idx]  <= s_axis_tdata[18:3];
                r_lob[w_idx]  <= s_axis_tdata[34:19];
                r_hib[w_idx]  <= s_axis_tdata[50:35];
                r_crit[w_idx] <= s_axis_tdata[51];
            end else if (w_op == OP_DEMAND) begin
                r_dem[w_idx]  <= s_axis_tdata[67:52];
            end
        end
    end

    // shared units
    always_ff @(posedge i_clk) begin
        r_mul <= w_mul_a * w_mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_cnt  <= '0;
        end else if (w_dv_go) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= '0;
            r_dv_rem  <= '0;
            r_dv_quo  <= w_dv_a;
            r_dv_dvs  <= w_dv_b;
        end else if (r_dv_busy) begin
            r_dv_rem  <= w_dv_ge ? UW'(w_dv_rs - {1'b0, r_dv_dvs}) : w_dv_rs[UW-1:0];
            r_dv_quo  <= {r_dv_quo[DVW-2:0], w_dv_ge};
            r_dv_cnt  <= r_dv_cnt + 1'b1;
            if (r_dv_cnt == DVCW'(DVW - 1)) r_dv_busy <= 1'b0;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int j = 0; j < MAX_TASKS; j++) begin
                r_phase[j]  <= PH_READY;
                r_raised[j] <= 1'b0;
                r_en[j]     <= 1'b1;
                r_exec[j]   <= '0;
                r_wake[j]   <= '0;
                r_vdl[j]    <= '0;
                r_rdl[j]    <= '0;
            end
            r_run    <= '0;
            r_run_v  <= 1'b0;
            r_mode   <= 1'b0;
            r_bud    <= '0;
            r_elu    <= '0;
            r_time   <= '0;
            r_qph    <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_best_v <= 1'b0;
            r_sched  <= 1'b0;
            r_dl     <= '0;
            r_dh     <= '0;
            r_ml     <= '0;
            r_mh     <= '0;
            r_dr     <= '0;
            r_out    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_i     <= '0;
                        r_sched <= 1'b0;
                        r_dl    <= '0;
                        r_dh    <= '0;
                        r_ml    <= '0;
                        r_mh    <= '0;
                        r_dr    <= '0;
                        r_out   <= '0;
                        if (w_op == OP_START) begin
                            r_run_v <= 1'b0;
                            r_mode  <= 1'b0;
                            r_bud   <= BW'(r_ucrit);
                            r_elu   <= r_ucrit;
                            r_time  <= '0;
                            r_qph   <= '0;
                        end
                    end
                end
                S_INIT: begin
                    r_phase[w_ii]  <= PH_READY;
                    r_raised[w_ii] <= 1'b0;
                    r_exec[w_ii]   <= '0;
                    r_wake[w_ii]   <= '0;
                    r_rdl[w_ii]    <= TW'(r_per[w_ii]);
                    r_vdl[w_ii]    <= r_crit[w_ii] ? w_scaled : TW'(r_per[w_ii]);
                    r_en[w_ii]     <= 1'b1;
                    r_i            <= r_i + 1'b1;
                end
                S_CHECK: begin
                    r_sched <= w_sched;
                    if (w_sched && r_run_v && w_run_done) begin
                        if (r_crit[r_run]) r_dh <= r_dh + 1'b1;
                        else               r_dl <= r_dl + 1'b1;
                        r_phase[r_run] <= PH_IDLE;
                        r_wake[r_run]  <= r_wake[r_run] + TW'(r_per[r_run]);
                        r_exec[r_run]  <= '0;
                        r_run_v        <= 1'b0;
                    end
                end
                S_RTEST: r_i <= '0;
                S_ULO_W: if (!r_dv_busy) r_ulo <= w_dv_sat;
                S_UHI_W: if (!r_dv_busy) r_uhi <= w_dv_sat;
                S_RQ_W:  if (!r_dv_busy) r_dmag <= w_dmag;
                S_BUD_W: if (!r_dv_busy) r_bud <= w_bnew;
                S_RSET: begin
                    // raise the mode; the overrunning job gets its real deadline back
                    r_mode          <= 1'b1;
                    r_raised[r_run] <= 1'b1;
                    r_vdl[r_run]    <= r_wake[r_run] + TW'(r_per[r_run]);
                    r_i             <= '0;
                    r_k             <= '0;
                end
                S_UTIL_W: begin
                    if (!r_dv_busy) begin
                        r_ulow[w_ii] <= w_dv_sat;
                        r_i          <= r_i + 1'b1;
                    end
                end
                S_DROP_CHK: begin
                    r_i      <= '0;
                    r_best_v <= 1'b0;
                end
                S_DROP_SCAN: begin
                    if (!w_end) begin
                        if (w_dcand) begin
                            r_best_v <= 1'b1;
                            r_best   <= w_ii;
                            r_best_u <= r_ulow[w_ii];
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i <= '0;
                        if (r_best_v) begin
                            r_en[r_best] <= 1'b0;
                            r_elu <= (r_elu > r_best_u) ? (r_elu - r_best_u) : '0;
                            r_dr  <= r_dr + 1'b1;
                            r_k   <= r_k + 1'b1;
                            if (r_run_v && r_run == r_best) r_run_v <= 1'b0;
                        end
                    end
                end
                S_MISS: begin
                    if (!w_end) begin
                        if (w_miss) begin
                            if (r_crit[w_ii]) r_mh <= r_mh + 1'b1;
                            else              r_ml <= r_ml + 1'b1;
                            r_phase[w_ii] <= PH_IDLE;
                            r_wake[w_ii]  <= w_wake_per;
                            r_exec[w_ii]  <= '0;
                            if (r_run_v && r_run == w_ii) r_run_v <= 1'b0;
                        end
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_i <= '0;
                    end
                end
                S_REL_MUL: begin
                    if (w_end) begin
                        r_i        <= '0;
                        r_best_v   <= r_run_v;
                        r_best     <= r_run;
                        r_best_vdl <= r_vdl[r_run];
                    end
                end
                S_REL: begin
                    if (w_rel) begin
                        r_phase[w_ii] <= PH_READY;
                        r_vdl[w_ii]   <= (r_crit[w_ii] && !r_raised[w_ii]) ?
                                         (r_wake[w_ii] + w_scaled) : w_wake_per;
                        r_rdl[w_ii]   <= w_wake_per;
                    end
                    r_i <= r_i + 1'b1;
                end
                S_PICK: begin
                    if (!w_end) begin
                        if (w_pcand) begin
                            r_best_v   <= 1'b1;
                            r_best     <= w_ii;
                            r_best_vdl <= r_vdl[w_ii];
                        end
                        r_i <= r_i + 1'b1;
                    end else if (r_best_v && !(r_run_v && r_best == r_run)) begin
                        // preempt: earlier virtual deadline takes the processor
                        if (r_run_v) r_phase[r_run] <= PH_READY;
                        r_phase[r_best] <= PH_RUNNING;
                        r_run           <= r_best;
                        r_run_v         <= 1'b1;
                    end
                end
                S_RCHK: begin
                    r_i <= '0;
                    if (!r_run_v && r_mode) begin
                        r_mode <= 1'b0;
                        r_bud  <= BW'(r_ucrit);
                        r_elu  <= r_ucrit;
                    end
                end
                S_RESTORE: begin
                    if (!w_end) begin
                        if (w_rcand) begin
                            r_run      <= w_ii;
                            r_run_v    <= 1'b1;
                            r_best_vdl <= r_vdl[w_ii];
                        end
                        if (!r_crit[w_ii]) r_en[w_ii]     <= 1'b1;
                        else               r_raised[w_ii] <= 1'b0;
                        r_i <= r_i + 1'b1;
                    end else if (r_run_v) begin
                        r_phase[r_run] <= PH_RUNNING;
                    end
                end
                S_EXEC: begin
                    if (r_run_v && r_exec[r_run] != 16'hFFFF)
                        r_exec[r_run] <= r_exec[r_run] + 16'd1;
                    r_out <= {6'd0, 32'(r_time), r_dr, r_mh, r_ml, r_dh, r_dl,
                              r_sched, r_mode, r_run_v,
                              (r_run_v ? 3'(r_run) : 3'd0)};
                    r_time <= r_time + 1'b1;
                    r_qph  <= (w_qnext >= {1'b0, w_q}) ? 16'd0 : w_qnext[15:0];
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request taken while a result is pending");

    a_idle_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out[3] || r_out[2:0] == 3'd0))
        else $error("running_task nonzero with no running job");

    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_dv_busy)
        else $error("divider busy while sequencer idle");

    a_run_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_run_v) |-> (r_phase[r_run] == PH_RUNNING))
        else $error("running slot not in running phase");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the EDF-VD mixed-criticality scheduler core.
`timescale 1ns / 1ps

// Keeps a behavioral copy of the scheduler and holds the expected result words.
class sched_scoreboard;
    // task table
    bit [15:0] period_t[8], lo_t[8], hi_t[8], dem_t[8];
    bit        crit_t[8];
    // per-task job state
    mcedf_pkg::t_phase phase_t[8];
    bit        raised_t[8], en_t[8];
    bit [15:0] exec_t[8];
    bit [31:0] wake_t[8], vdl_t[8], rdl_t[8];
    // global state
    int          run;
    bit          mode;
    longint      bud_left, en_util;
    bit [31:0]   now;
    int unsigned qphase;
    // registers
    bit [15:0] quantum, lambda;
    bit [3:0]  tcount;
    bit [16:0] ulow, uhigh;

    logic [63:0] sched_results_q[$];
    int errors;

    function longint util(bit [15:0] b, int i);
        longint p, u;
        p = period_t[i] != 0 ? period_t[i] : 1;
        u = (longint'(b) << 16) / p;
        return u > 65536 ? 65536 : u;
    endfunction

    function bit [31:0] scaled(int i);
        longint v;
        v = (longint'(period_t[i]) * longint'(lambda)) >> 16;
        return v[31:0];
    endfunction

    function void retire(int i);
        phase_t[i] = mcedf_pkg::PH_IDLE;
        wake_t[i]  = wake_t[i] + period_t[i];
        exec_t[i]  = 0;
        if (run == i) run = -1;
    endfunction

    function bit overran(int i);
        return exec_t[i] > lo_t[i] && !raised_t[i];
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) begin
            phase_t[i]  = mcedf_pkg::PH_READY;
            raised_t[i] = 0;
            exec_t[i]   = 0;
            wake_t[i]   = 0;
            rdl_t[i]    = period_t[i];
            vdl_t[i]    = crit_t[i] ? scaled(i) : 32'(period_t[i]);
            en_t[i]     = 1;
        end
        run      = -1;
        mode     = 0;
        bud_left = ulow;
        en_util  = ulow;
        now      = 0;
        qphase   = 0;
    endfunction

    function void reset_state();
        for (int i = 0; i < 8; i++) begin
            period_t[i] = 0; lo_t[i] = 0; hi_t[i] = 0; dem_t[i] = 0; crit_t[i] = 0;
        end
        quantum = 1; tcount = 1; ulow = 0; uhigh = 65536; lambda = 65535;
        errors = 0;
        restart();
    endfunction

    function void set_reg(bit [2:0] idx, bit [16:0] val);
        case (idx)
            mcedf_pkg::CFG_QUANTUM: quantum = val[15:0];
            mcedf_pkg::CFG_TCOUNT:  tcount  = val[3:0];
            mcedf_pkg::CFG_ULOW:    ulow    = val;
            mcedf_pkg::CFG_UHIGH:   uhigh   = val;
            mcedf_pkg::CFG_LAMBDA:  lambda  = val[15:0];
            default: ;
        endcase
    endfunction

    // mode raise on a high-task overrun; returns the number of low tasks dropped
    function int raise_mode(int r, int n);
        longint ulo, uhi, omu, h, den, d, bu, u;
        int dropped, best;
        ulo = util(lo_t[r], r);
        uhi = util(hi_t[r], r);
        omu = ulow < 65536 ? 65536 - longint'(ulow) : 0;
        h   = uhigh != 0 ? longint'(uhigh) : 1;
        den = 65536 - longint'(lambda);
        d   = (ulo * omu) / h - uhi;
        dropped = 0;
        mode = 1;
        raised_t[r] = 1;
        vdl_t[r] = wake_t[r] + period_t[r];
        if (d < 0) begin
            bud_left += (d * 65536) / den;
            if (bud_left < -8388608) bud_left = -8388608;
            if (bud_left > 8388607) bud_left = 8388607;
        end
        for (int k = 0; k < 8; k++) begin
            if (!(en_util > bud_left && en_util > longint'(mcedf_pkg::EPS_Q))) break;
            best = -1;
            bu = 0;
            for (int i = 0; i < n; i++) begin
                u = util(lo_t[i], i);
                if (!crit_t[i] && en_t[i] && (best < 0 || u > bu)) begin
                    best = i;
                    bu = u;
                end
            end
            if (best < 0) break;
            en_t[best] = 0;
            en_util = en_util > bu ? en_util - bu : 0;
            dropped++;
            if (run == best) run = -1;
        end
        return dropped;
    endfunction

    function void note_request(mcedf_pkg::t_op op, bit [2:0] idx, bit [15:0] per,
                               bit [15:0] lo, bit [15:0] hi, bit crit, bit [15:0] dem);
        int n, r, best, dr;
        int unsigned dl, dh, ml, mh, q;
        bit [31:0] t;
        bit sched;
        if (op == mcedf_pkg::OP_LOAD) begin
            period_t[idx] = per; lo_t[idx] = lo; hi_t[idx] = hi; crit_t[idx] = crit;
            sched_results_q.push_back(64'd0);
            return;
        end
        if (op == mcedf_pkg::OP_DEMAND) begin
            dem_t[idx] = dem;
            sched_results_q.push_back(64'd0);
            return;
        end
        if (op == mcedf_pkg::OP_START) begin
            restart();
            sched_results_q.push_back(64'd0);
            return;
        end
        n = tcount > 8 ? 8 : tcount;
        r = run;
        t = now;
        q = quantum != 0 ? quantum : 1;
        dl = 0; dh = 0; ml = 0; mh = 0; dr = 0;
        sched = (qphase == 0);
        if (r >= 0 && (exec_t[r] >= dem_t[r] || overran(r) || t > rdl_t[r])) sched = 1;
        if (sched) begin
            // retire the finished job
            if (r >= 0 && exec_t[r] >= dem_t[r]) begin
                if (crit_t[r]) dh++; else dl++;
                retire(r);
            end
            r = run;
            if (r >= 0 && overran(r) && crit_t[r]) dr = raise_mode(r, n);
            // deadline misses and overruns
            for (int i = 0; i < n; i++)
                if ((phase_t[i] == mcedf_pkg::PH_READY || phase_t[i] == mcedf_pkg::PH_RUNNING)
                        && (t > rdl_t[i] || overran(i))) begin
                    if (crit_t[i]) mh++; else ml++;
                    retire(i);
                end
            // releases
            for (int i = 0; i < n; i++)
                if (phase_t[i] == mcedf_pkg::PH_IDLE && t >= wake_t[i]) begin
                    phase_t[i] = mcedf_pkg::PH_READY;
                    if (crit_t[i] && !raised_t[i]) vdl_t[i] = wake_t[i] + scaled(i);
                    else vdl_t[i] = wake_t[i] + period_t[i];
                    rdl_t[i] = wake_t[i] + period_t[i];
                end
            // earliest virtual deadline
            best = run;
            for (int i = 0; i < n; i++)
                if (phase_t[i] == mcedf_pkg::PH_READY && en_t[i]
                        && (best < 0 || vdl_t[i] < vdl_t[best]))
                    best = i;
            if (best != run) begin
                if (run >= 0) phase_t[run] = mcedf_pkg::PH_READY;
                phase_t[best] = mcedf_pkg::PH_RUNNING;
                run = best;
            end
            // back to low mode when nothing is left to run
            if (run < 0 && mode) begin
                mode = 0;
                bud_left = ulow;
                en_util = ulow;
                for (int i = 0; i < n; i++) begin
                    if (phase_t[i] == mcedf_pkg::PH_READY && (run < 0 || vdl_t[i] < vdl_t[run]))
                        run = i;
                    if (!crit_t[i]) en_t[i] = 1; else raised_t[i] = 0;
                end
                if (run >= 0) phase_t[run] = mcedf_pkg::PH_RUNNING;
            end
        end
        if (run >= 0 && exec_t[run] != 16'hFFFF) exec_t[run]++;
        sched_results_q.push_back({6'd0, t, 4'(dr), 4'(mh), 4'(ml), 4'(dh), 4'(dl),
                                   sched, mode, run >= 0, run >= 0 ? 3'(run) : 3'd0});
        now = t + 1;
        qphase++;
        if (qphase >= q) qphase = 0;
    endfunction

    function void check_result(logic [63:0] got);
        int lsb[10] = '{0, 3, 4, 5, 6, 10, 14, 18, 22, 26};
        int wid[10] = '{3, 1, 1, 1, 4, 4, 4, 4, 4, 32};
        string fname[10] = '{"running_task", "running_valid", "high_mode_active", "sched_point",
                             "done_low_count", "done_high_count", "miss_low_count",
                             "miss_high_count", "dropped_count", "current_time"};
        logic [63:0] want;
        logic [31:0] mask, e, a;
        bit bad;
        if (sched_results_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
        end
        want = sched_results_q.pop_front();
        bad = 0;
        for (int f = 0; f < 10; f++) begin
            mask = wid[f] == 32 ? 32'hFFFF_FFFF : (32'd1 << wid[f]) - 1;
            e = 32'(want >> lsb[f]) & mask;
            a = 32'(got >> lsb[f]) & mask;
            if (a !== e) begin
                if (!bad) errors++;
                if (errors <= 10)
                    $display("mismatch %s: expected %0h, got %0h", fname[f], e, a);
                bad = 1;
            end
        end
    endfunction
endclass

module tb_top;
    import mcedf_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [16:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;

    sched_scoreboard sb = new();
    bit quiet = 0;          // no idling in the closing part of the run
    bit held = 0;           // the long receiver hold-off has happened
    int results_seen = 0;
    int cycles = 0;

    mixed_criticality_edf_vd_drop_scheduler_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
            results_seen++;
        end

    // receiver: random stall bursts plus one long hold-off so the core backs up
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 250) begin
                held = 1;
                m_axis_tready <= 0;
                repeat (700) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 10);
                m_axis_tready <= 0;
                repeat (k - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    task automatic send_request(t_op op, bit [2:0] idx, bit [15:0] per, bit [15:0] lo,
                                bit [15:0] hi, bit crit, bit [15:0] dem);
        int k;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            k = $urandom_range(1, 10);
            @(negedge i_clk);
            s_axis_tvalid <= 0;
            repeat (k - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, dem, crit, hi, lo, per, idx};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        sb.note_request(op, idx, per, lo, hi, crit, dem);
    endtask

    task automatic tick();
        send_request(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic set_demand(bit [2:0] idx, bit [15:0] dem);
        send_request(OP_DEMAND, idx, $urandom, $urandom, $urandom, $urandom, dem);
    endtask

    // mostly well-formed task: short period, small budgets, demand near the low budget; now and then random
    task automatic load_task(bit [2:0] idx);
        bit [15:0] per, lo, hi;
        per = $urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(2, 40));
        lo  = $urandom_range(0, 20) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
        hi  = $urandom_range(0, 20) == 0 ? 16'($urandom) : lo + 16'($urandom_range(0, 12));
        send_request(OP_LOAD, idx, per, lo, hi, $urandom, $urandom);
        set_demand(idx, $urandom_range(0, 20) == 0 ? 16'($urandom)
                                                   : lo + 16'($urandom_range(0, 4)) - 16'd1);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [16:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // registers change only once every result is back and the core has settled
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (sb.sched_results_q.size() != 0) @(posedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        int nticks;
        sb.reset_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: table and field extremes, every opcode, zero period, zero demand
        write_reg(CFG_QUANTUM, 2);
        write_reg(CFG_TCOUNT, 8);
        write_reg(CFG_ULOW, 30000);
        write_reg(CFG_UHIGH, 40000);
        write_reg(CFG_LAMBDA, 40000);
        send_request(OP_LOAD, 0, 16'hFFFF, 16'd0, 16'hFFFF, 1, 16'd0);
        send_request(OP_LOAD, 1, 16'd1, 16'hFFFF, 16'd0, 0, 16'hFFFF);
        send_request(OP_LOAD, 2, 16'd0, 16'd3, 16'd5, 0, 16'd0);
        send_request(OP_LOAD, 3, 16'd10, 16'd2, 16'd6, 1, 16'd0);
        send_request(OP_LOAD, 4, 16'd12, 16'd4, 16'd4, 0, 16'd0);
        send_request(OP_LOAD, 5, 16'd20, 16'd1, 16'd9, 1, 16'd0);
        send_request(OP_LOAD, 6, 16'd8, 16'd3, 16'd3, 0, 16'd0);
        send_request(OP_LOAD, 7, 16'd16, 16'd5, 16'd7, 0, 16'd0);
        set_demand(0, 16'd0);
        set_demand(1, 16'hFFFF);
        set_demand(3, 16'd5);
        set_demand(5, 16'd4);
        send_request(OP_START, 0, 0, 0, 0, 0, 0);
        repeat (10) tick();

        // random phases with register settings swept across their extremes
        for (int ph = 0; ph < 10; ph++) begin
            wait_idle();
            if (ph >= 8) quiet = 1;
            write_reg(CFG_QUANTUM, ph == 0 ? 0 : ph == 9 ? 65535 :
                      $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 6));
            write_reg(CFG_TCOUNT, ph == 1 ? 0 : ph == 2 ? 15 : $urandom_range(1, 8));
            write_reg(CFG_ULOW, ph == 0 ? 0 : ph == 9 ? 131071 : ph == 5 ? 65536 :
                      $urandom_range(0, 70000));
            write_reg(CFG_UHIGH, ph == 0 ? 0 : ph == 9 ? 131071 : ph == 3 ? 1 :
                      $urandom_range(1, 65536));
            write_reg(CFG_LAMBDA, ph == 0 ? 0 : ph == 9 ? 65535 : $urandom_range(0, 65535));
            for (int i = 0; i < 8; i++) load_task(i);
            send_request(OP_START, 0, 0, 0, 0, 0, 0);
            nticks = 150;
            for (int j = 0; j < nticks; j++) begin
                case ($urandom_range(0, 39))
                    0, 1: set_demand($urandom, $urandom_range(0, 15));
                    2:    load_task($urandom);
                    3:    send_request(t_op'($urandom), $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom);
                    default: tick();
                endcase
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 0;
        while (sb.sched_results_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (sb.errors == 0 && sb.sched_results_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
